// ===== src/hso_pkg.sv =====
// Shared types and constants for the HSV saturation offset pipeline.
package hso_pkg;

  localparam int unsigned FractionBitsDef = 16;

  // Which channel holds the maximum; ties go to red, then green.
  typedef enum logic [1:0] {
    HUE_RED,
    HUE_GREEN,
    HUE_BLUE
  } hue_sel_e;

  // Hue sector codes; sector five is the default arm.
  localparam logic [2:0] SecRedYel   = 3'd0;
  localparam logic [2:0] SecYelGrn   = 3'd1;
  localparam logic [2:0] SecGrnCyan  = 3'd2;
  localparam logic [2:0] SecCyanBlue = 3'd3;
  localparam logic [2:0] SecBlueMag  = 3'd4;

  // Per-pixel side information carried through the divider.
  typedef struct packed {
    logic [7:0] v;
    logic [7:0] delta;
    logic [7:0] hnum;
    logic       hneg;
    hue_sel_e   hsel;
    logic       gray;
    logic       last;
  } prep_t;

endpackage

// ===== src/hsv_saturation_offset_unit.sv =====
// Top level: RGB pixel saturation offset through HSV, fully pipelined.
//
//   channel   direction  handshake               word
//   in        input      in_valid_i/in_ready_o   in_red/green/blue_i, in_last_i
//   out       output     out_valid_o/out_ready_i out_red/green/blue_o, out_last_o
//   cfg       input      cfg_we_i (no wait)      cfg_saturation_offset_pct_i
//
// One word enters per cycle unless the output stalls; words pass the prep stage, the
// bit-per-stage divider that forms hue and saturation, the adjust stage and RGB stages.
// Every stage has its own valid bit and advances when the next stage is empty
// or moving, so bubbles close up while the output is stalled.
// Reset clears the valid bits and the offset register (offset zero).
// A written offset reaches the pipeline through one extra register stage.
module hsv_saturation_offset_unit #(
  parameter int unsigned FracBits = hso_pkg::FractionBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_red_i,
  input  logic [7:0] in_green_i,
  input  logic [7:0] in_blue_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic       out_last_o,
  input  logic       cfg_we_i,
  input  logic signed [7:0] cfg_saturation_offset_pct_i
);
  import hso_pkg::*;

  localparam int unsigned PctMagMax = 128;

  logic signed [7:0]  pct_q;
  logic [7:0]         pct_mag;
  logic [FracBits:0]  off_tbl [0:PctMagMax];
  logic [FracBits:0]  off_mag_q;
  logic               off_neg_q;

  logic               prep_valid, prep_ready;
  prep_t              prep_side;
  logic               div_valid, div_ready;
  prep_t              div_side;
  logic [FracBits:0]  div_hq, div_sq;
  logic               adj_valid, adj_ready;
  logic [7:0]         adj_v;
  logic               adj_last;
  logic [2:0]         adj_sector;
  logic [FracBits-1:0] adj_frac;
  logic [FracBits:0]  adj_sat;

  // Offset in saturation units: floor(|pct| * ONE / 100), sign kept apart.
  for (genvar k = 0; k <= PctMagMax; k++) begin : g_off
    localparam logic [63:0] OffVal = (64'(k) << FracBits) / 100;
    assign off_tbl[k] = OffVal[FracBits:0];
  end

  assign pct_mag = pct_q[7] ? 8'(-pct_q) : pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q     <= '0;
      off_mag_q <= '0;
      off_neg_q <= 1'b0;
    end else begin
      if (cfg_we_i) pct_q <= cfg_saturation_offset_pct_i;
      off_mag_q <= off_tbl[pct_mag];
      off_neg_q <= pct_q[7];
    end
  end

  hso_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .red_i   (in_red_i),
    .green_i (in_green_i),
    .blue_i  (in_blue_i),
    .last_i  (in_last_i),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .side_o  (prep_side)
  );

  hso_div #(.FracBits(FracBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .side_i  (prep_side),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .side_o  (div_side),
    .hq_o    (div_hq),
    .sq_o    (div_sq)
  );

  hso_adj #(.FracBits(FracBits)) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_valid),
    .ready_o   (div_ready),
    .side_i    (div_side),
    .hq_i      (div_hq),
    .sq_i      (div_sq),
    .off_mag_i (off_mag_q),
    .off_neg_i (off_neg_q),
    .valid_o   (adj_valid),
    .ready_i   (adj_ready),
    .v_o       (adj_v),
    .last_o    (adj_last),
    .sector_o  (adj_sector),
    .frac_o    (adj_frac),
    .sat_o     (adj_sat)
  );

  hso_rgb #(.FracBits(FracBits)) u_rgb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (adj_valid),
    .ready_o  (adj_ready),
    .v_i      (adj_v),
    .last_i   (adj_last),
    .sector_i (adj_sector),
    .frac_i   (adj_frac),
    .sat_i    (adj_sat),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .red_o    (out_red_o),
    .green_o  (out_green_o),
    .blue_o   (out_blue_o),
    .last_o   (out_last_o)
  );

endmodule

// ===== src/hso_prep.sv =====
// First stage: max, min, delta and hue numerator of one pixel.
module hso_prep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [7:0]    red_i,
  input  logic [7:0]    green_i,
  input  logic [7:0]    blue_i,
  input  logic          last_i,
  output logic          valid_o,
  input  logic          ready_i,
  output hso_pkg::prep_t side_o
);
  import hso_pkg::*;

  logic       valid_q;
  prep_t      side_d, side_q;
  logic [7:0] mx, mn;
  logic [8:0] diff;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign side_o  = side_q;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    priority if (red_i >= green_i && red_i >= blue_i) begin
      side_d.hsel = HUE_RED;
      diff        = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      side_d.hsel = HUE_GREEN;
      diff        = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      side_d.hsel = HUE_BLUE;
      diff        = {1'b0, red_i} - {1'b0, green_i};
    end

    side_d.v     = mx;
    side_d.delta = mx - mn;
    side_d.hneg  = diff[8];
    side_d.hnum  = diff[8] ? 8'(-diff) : diff[7:0];
    side_d.gray  = (mx == mn);
    side_d.last  = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      side_q <= side_d;
    end
  end

endmodule

// ===== src/hso_div.sv =====
// Pipelined restoring divider: hue ratio and saturation, one quotient bit per stage.
module hso_div #(
  parameter int unsigned FracBits = hso_pkg::FractionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hso_pkg::prep_t      side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hso_pkg::prep_t      side_o,
  output logic [FracBits:0]   hq_o,
  output logic [FracBits:0]   sq_o
);
  import hso_pkg::*;

  localparam int unsigned NStg = FracBits + 1;

  logic                vld_q  [NStg];
  prep_t               side_q [NStg];
  logic [7:0]          rh_q   [NStg];
  logic [7:0]          rs_q   [NStg];
  logic [FracBits:0]   qh_q   [NStg];
  logic [FracBits:0]   qs_q   [NStg];
  logic [NStg:0]       rdy;

  logic ge_h0, ge_s0;

  assign rdy[NStg] = ready_i;
  assign ready_o   = rdy[0];
  assign valid_o   = vld_q[NStg-1];
  assign side_o    = side_q[NStg-1];
  assign hq_o      = qh_q[NStg-1];
  assign sq_o      = qs_q[NStg-1];

  // Integer bit: numerator never exceeds the divisor.
  assign ge_h0 = side_i.hnum >= side_i.delta;
  assign ge_s0 = side_i.delta >= side_i.v;

  assign rdy[0] = !vld_q[0] || rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy[0]) begin
      side_q[0] <= side_i;
      rh_q[0]   <= ge_h0 ? side_i.hnum - side_i.delta : side_i.hnum;
      rs_q[0]   <= ge_s0 ? side_i.delta - side_i.v : side_i.delta;
      qh_q[0]   <= {{FracBits{1'b0}}, ge_h0};
      qs_q[0]   <= {{FracBits{1'b0}}, ge_s0};
    end
  end

  for (genvar k = 1; k < NStg; k++) begin : g_stg
    logic [8:0] sh_h, sh_s;
    logic       ge_h, ge_s;

    assign sh_h = {rh_q[k-1], 1'b0};
    assign sh_s = {rs_q[k-1], 1'b0};
    assign ge_h = sh_h >= {1'b0, side_q[k-1].delta};
    assign ge_s = sh_s >= {1'b0, side_q[k-1].v};
    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[k-1] && rdy[k]) begin
        side_q[k] <= side_q[k-1];
        rh_q[k]   <= ge_h ? 8'(sh_h - {1'b0, side_q[k-1].delta}) : sh_h[7:0];
        rs_q[k]   <= ge_s ? 8'(sh_s - {1'b0, side_q[k-1].v}) : sh_s[7:0];
        qh_q[k]   <= {qh_q[k-1][FracBits-1:0], ge_h};
        qs_q[k]   <= {qs_q[k-1][FracBits-1:0], ge_s};
      end
    end
  end

endmodule

// ===== src/hso_adj.sv =====
// Hue assembly and saturation offset with clamp to zero..one.
module hso_adj #(
  parameter int unsigned FracBits = hso_pkg::FractionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hso_pkg::prep_t      side_i,
  input  logic [FracBits:0]   hq_i,
  input  logic [FracBits:0]   sq_i,
  input  logic [FracBits:0]   off_mag_i,
  input  logic                off_neg_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [7:0]          v_o,
  output logic                last_o,
  output logic [2:0]          sector_o,
  output logic [FracBits-1:0] frac_o,
  output logic [FracBits:0]   sat_o
);
  import hso_pkg::*;

  localparam int unsigned HW = FracBits + 3;
  localparam logic [HW-1:0] One  = {2'b00, 1'b1, {FracBits{1'b0}}};
  localparam logic [HW-1:0] Two  = One << 1;
  localparam logic [HW-1:0] Four = One << 2;
  localparam logic [HW-1:0] Six  = (One << 2) + (One << 1);

  logic                  valid_q;
  logic [HW-1:0]         hq_ext, hue;
  logic signed [HW-1:0]  s_ext, off_ext, sum;
  logic [FracBits:0]     sat_d;

  logic [7:0]            v_q;
  logic                  last_q;
  logic [2:0]            sector_q;
  logic [FracBits-1:0]   frac_q;
  logic [FracBits:0]     sat_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign v_o      = v_q;
  assign last_o   = last_q;
  assign sector_o = sector_q;
  assign frac_o   = frac_q;
  assign sat_o    = sat_q;

  always_comb begin
    hq_ext = {2'b00, hq_i};
    unique case (side_i.hsel)
      HUE_RED:   hue = side_i.hneg ? Six - hq_ext : hq_ext;
      HUE_GREEN: hue = side_i.hneg ? Two - hq_ext : Two + hq_ext;
      default:   hue = side_i.hneg ? Four - hq_ext : Four + hq_ext;
    endcase
    if (side_i.gray) hue = '0;

    s_ext   = side_i.gray ? '0 : signed'({2'b00, sq_i});
    off_ext = signed'({2'b00, off_mag_i});
    sum     = off_neg_i ? s_ext - off_ext : s_ext + off_ext;

    priority if (sum[HW-1]) begin
      sat_d = '0;
    end else if (sum > signed'(One)) begin
      sat_d = One[FracBits:0];
    end else begin
      sat_d = sum[FracBits:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      v_q      <= side_i.v;
      last_q   <= side_i.last;
      sector_q <= hue[HW-1:FracBits];
      frac_q   <= hue[FracBits-1:0];
      sat_q    <= sat_d;
    end
  end

endmodule

// ===== src/hso_rgb.sv =====
// Two-stage HSV to RGB back conversion: p and saturation products, then q, t and sector select.
module hso_rgb #(
  parameter int unsigned FracBits = hso_pkg::FractionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          v_i,
  input  logic                last_i,
  input  logic [2:0]          sector_i,
  input  logic [FracBits-1:0] frac_i,
  input  logic [FracBits:0]   sat_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic                last_o
);
  import hso_pkg::*;

  localparam int unsigned PW = 2 * FracBits + 1;
  localparam int unsigned VW = FracBits + 9;
  localparam logic [FracBits:0] One = {1'b1, {FracBits{1'b0}}};

  // Stage one
  logic              v1_valid_q, rdy1;
  logic [PW-1:0]     prod_sf, prod_s1f;
  logic [VW-1:0]     prod_p;
  logic [FracBits:0] om_frac;
  logic [7:0]        v1_q, p1_q;
  logic              last1_q, szero1_q;
  logic [2:0]        sector1_q;
  logic [FracBits:0] sf1_q, s1f1_q;

  // Stage two
  logic              v2_valid_q;
  logic [VW-1:0]     prod_q, prod_t;
  logic [7:0]        qv, tv, red_d, green_d, blue_d;
  logic [7:0]        red_q, green_q, blue_q;
  logic              last2_q;

  assign ready_o = !v1_valid_q || rdy1;
  assign rdy1    = !v2_valid_q || ready_i;
  assign valid_o = v2_valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign last_o  = last2_q;

  always_comb begin
    om_frac  = One - {1'b0, frac_i};
    prod_sf  = PW'(sat_i) * PW'(frac_i);
    prod_s1f = PW'(sat_i) * PW'(om_frac);
    prod_p   = VW'(v_i) * VW'(One - sat_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_valid_q <= 1'b0;
      v2_valid_q <= 1'b0;
    end else begin
      if (ready_o) v1_valid_q <= valid_i;
      if (rdy1) v2_valid_q <= v1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      v1_q      <= v_i;
      last1_q   <= last_i;
      sector1_q <= sector_i;
      szero1_q  <= (sat_i == '0);
      sf1_q     <= prod_sf[2*FracBits:FracBits];
      s1f1_q    <= prod_s1f[2*FracBits:FracBits];
      p1_q      <= prod_p[FracBits+7:FracBits];
    end
  end

  always_comb begin
    prod_q = VW'(v1_q) * VW'(One - sf1_q);
    prod_t = VW'(v1_q) * VW'(One - s1f1_q);
    qv     = prod_q[FracBits+7:FracBits];
    tv     = prod_t[FracBits+7:FracBits];
    unique case (sector1_q)
      SecRedYel:   begin red_d = v1_q; green_d = tv;   blue_d = p1_q; end
      SecYelGrn:   begin red_d = qv;   green_d = v1_q; blue_d = p1_q; end
      SecGrnCyan:  begin red_d = p1_q; green_d = v1_q; blue_d = tv;   end
      SecCyanBlue: begin red_d = p1_q; green_d = qv;   blue_d = v1_q; end
      SecBlueMag:  begin red_d = tv;   green_d = p1_q; blue_d = v1_q; end
      default:     begin red_d = v1_q; green_d = p1_q; blue_d = qv;   end
    endcase
    // Zero saturation: gray output at the value level.
    if (szero1_q) begin
      red_d   = v1_q;
      green_d = v1_q;
      blue_d  = v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_valid_q && rdy1) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      last2_q <= last1_q;
    end
  end

endmodule
